>>> hw/rtl/tcwc_pkg.sv
// tcwc_pkg: shared types and constants for the congestion window controller
// holds command, event, phase and register codes, the sequencer state type and field widths
// no dependencies
`timescale 1ns / 1ps

package tcwc_pkg;

  // field widths
  localparam int unsigned SegsW  = 10;
  localparam int unsigned MssW   = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned RtoW   = 35;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW = 2;

  // segments * mss, and segments * mss * mss
  localparam int unsigned Prod1W = SegsW + MssW;
  localparam int unsigned ProdW  = SegsW + 2 * MssW;
  // window plus the widest increment
  localparam int unsigned SumW   = ProdW + 1;
  // one quotient bit per divider step
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // packed port widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 168;

  // reset values
  localparam logic [MssW-1:0]  MssReset       = 16'd1460;
  localparam logic [WordW-1:0] CeilingReset   = 32'd65535;
  localparam logic [WordW-1:0] ThresholdReset = 32'h7fff_ffff;

  // commands carried in tuser
  localparam logic [CmdW-1:0] CMD_ACK   = 2'd0;
  localparam logic [CmdW-1:0] CMD_EVENT = 2'd1;
  localparam logic [CmdW-1:0] CMD_STATE = 2'd2;

  // congestion events
  localparam logic [CodeW-1:0] EV_LOSS     = 3'd0;
  localparam logic [CodeW-1:0] EV_TIMEOUT  = 3'd1;
  localparam logic [CodeW-1:0] EV_ECN      = 3'd2;
  localparam logic [CodeW-1:0] EV_FAST_REC = 3'd3;

  // congestion phases
  localparam logic [PhaseW-1:0] PH_OPEN     = 3'd0;
  localparam logic [PhaseW-1:0] PH_CWR      = 3'd2;
  localparam logic [PhaseW-1:0] PH_RECOVERY = 3'd3;
  localparam logic [PhaseW-1:0] PH_LOSS     = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_CEILING = 2'd1;

  // sequencer states
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL1  = 9'b000000010,
    ST_MUL2  = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_GROW  = 9'b000010000,
    ST_EVT   = 9'b000100000,
    ST_SETP  = 9'b001000000,
    ST_RTT   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } seq_state_t;

endpackage

>>> hw/rtl/tcp_congestion_window_control_core.sv
// Reno congestion window controller: window growth, congestion events, phase writes, rtt/rto
// depends on tcwc_pkg
`timescale 1ns / 1ps

// One item is taken at a time; in_tready is high only while the sequencer is idle. An ack
// that grows the window in congestion avoidance makes two passes through the shared
// 26x16 multiplier to form segments*mss*mss, then a restoring divider produces one of 42
// quotient bits per cycle against the current window. A result waits in the output
// register until taken; the next item may be accepted meanwhile, but its result is held
// back until the register frees.
// The configuration channel is always ready; write it only while the block is idle.
module tcp_congestion_window_control_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // segments_acked, rtt_sample, event_code, new_state (lowest first)
  input  logic [tcwc_pkg::InDataW-1:0]  in_tdata,
  // cmd
  input  logic [tcwc_pkg::CmdW-1:0]     in_tuser,
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // window_bytes, threshold_bytes, phase, smoothed_rtt, rtt_spread, retransmit_timeout,
  // then two zero bits (lowest first)
  output logic [tcwc_pkg::OutDataW-1:0] out_tdata,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcwc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tcwc_pkg::WordW-1:0]    cfg_data
);
  import tcwc_pkg::*;

  // configuration
  logic [MssW-1:0]   mss_r;
  logic [WordW-1:0]  ceiling_r;

  // controller state
  logic [WordW-1:0]  window_r,    window_nxt;
  logic [WordW-1:0]  thresh_r,    thresh_nxt;
  logic [PhaseW-1:0] phase_r,     phase_nxt;
  logic [WordW-1:0]  rtt_r,       rtt_nxt;
  logic [WordW-1:0]  var_r,       var_nxt;
  logic [RtoW-1:0]   rto_r,       rto_nxt;

  // captured item
  logic [SegsW-1:0]  segs_r;
  logic [WordW-1:0]  sample_r;
  logic [CodeW-1:0]  ev_r;
  logic [CodeW-1:0]  ns_r;

  // sequencer and shared arithmetic
  seq_state_t        state_r, state_nxt;
  logic [ProdW-1:0]  prod_r,  prod_nxt;
  logic [WordW-1:0]  rem_r,   rem_nxt;
  logic [WordW-1:0]  div_r,   div_nxt;
  logic [DivCntW-1:0] cnt_r,  cnt_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r,  out_data_nxt;

  logic              in_xfer;
  logic              out_free;
  logic [Prod1W-1:0] mul_a;
  logic [ProdW-1:0]  mul_p;
  logic [WordW:0]    trial;
  logic [WordW-1:0]  halved;
  logic [WordW-1:0]  floor2;
  logic              slow_start;
  logic [ProdW-1:0]  inc;
  logic [SumW-1:0]   grown;
  logic [RtoW-1:0]   var_sum;
  logic [WordW-1:0]  var_new;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // shared multiplier: segments*mss, then (segments*mss)*mss
  assign mul_a = (state_r == ST_MUL1) ? {{MssW{1'b0}}, segs_r} : prod_r[Prod1W-1:0];
  assign mul_p = {{MssW{1'b0}}, mul_a} * ProdW'(mss_r);

  // restoring divider step: bring down the next dividend bit
  assign trial = {rem_r, prod_r[ProdW-1]};

  // threshold halving rule
  assign floor2 = {{(WordW-MssW-1){1'b0}}, mss_r, 1'b0};
  assign halved = ((window_r >> 1) > floor2) ? (window_r >> 1) : floor2;

  assign slow_start = (window_r < thresh_r);

  // growth: increment and capped window
  always_comb begin
    inc = (prod_r == '0) ? ProdW'(1) : prod_r;
    if (phase_r == PH_RECOVERY) begin
      grown = SumW'(window_r) + SumW'(prod_r[Prod1W-1:0]);
    end else if (slow_start) begin
      grown = SumW'(window_r) + SumW'(prod_r[Prod1W-1:0]);
      if (grown > SumW'(thresh_r)) begin
        grown = SumW'(thresh_r);
      end
    end else begin
      grown = SumW'(window_r) + SumW'(inc);
    end
    if (grown > SumW'(ceiling_r)) begin
      grown = SumW'(ceiling_r);
    end
  end

  // rtt variance update
  assign var_sum = RtoW'(var_r) + RtoW'({var_r, 1'b0}) + RtoW'(sample_r);
  assign var_new = (var_r == '0) ? (sample_r >> 1) : var_sum[WordW+1:2];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    thresh_nxt    = thresh_r;
    phase_nxt     = phase_r;
    rtt_nxt       = rtt_r;
    var_nxt       = var_r;
    rto_nxt       = rto_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            CMD_ACK: begin
              if (in_tdata[SegsW-1:0] != '0) begin
                state_nxt = ST_MUL1;
              end else begin
                state_nxt = ST_RTT;
              end
            end
            CMD_EVENT: state_nxt = ST_EVT;
            CMD_STATE: state_nxt = ST_SETP;
            default:   state_nxt = ST_OUT;
          endcase
        end
      end
      // segments * mss; avoidance needs a second pass and the divider
      ST_MUL1: begin
        prod_nxt = mul_p;
        if (phase_r == PH_RECOVERY || slow_start) begin
          state_nxt = ST_GROW;
        end else begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        prod_nxt  = mul_p;
        rem_nxt   = '0;
        div_nxt   = (window_r == '0) ? WordW'(1) : window_r;
        cnt_nxt   = DivCntW'(DivSteps - 1);
        state_nxt = ST_DIV;
      end
      // one quotient bit per cycle, quotient shifts into the dividend register
      ST_DIV: begin
        if (trial >= {1'b0, div_r}) begin
          rem_nxt  = WordW'(trial - {1'b0, div_r});
          prod_nxt = {prod_r[ProdW-2:0], 1'b1};
        end else begin
          rem_nxt  = trial[WordW-1:0];
          prod_nxt = {prod_r[ProdW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_GROW;
        end
      end
      ST_GROW: begin
        window_nxt = grown[WordW-1:0];
        state_nxt  = ST_RTT;
      end
      // congestion events
      ST_EVT: begin
        case (ev_r)
          EV_LOSS: begin
            thresh_nxt = halved;
            phase_nxt  = PH_RECOVERY;
          end
          EV_TIMEOUT: begin
            thresh_nxt = halved;
            window_nxt = WordW'(mss_r);
            phase_nxt  = PH_LOSS;
          end
          EV_ECN: begin
            thresh_nxt = halved;
            window_nxt = halved;
            phase_nxt  = PH_CWR;
          end
          EV_FAST_REC: phase_nxt = PH_RECOVERY;
          default: ;
        endcase
        state_nxt = ST_RTT;
      end
      // phase write; codes above loss are ignored
      ST_SETP: begin
        if (ns_r <= PH_LOSS) begin
          phase_nxt = ns_r;
          if (ns_r == PH_RECOVERY || ns_r == PH_LOSS) begin
            thresh_nxt = halved;
          end
        end
        state_nxt = ST_OUT;
      end
      // rtt, variance and timeout from a nonzero sample
      ST_RTT: begin
        if (sample_r != '0) begin
          rtt_nxt = sample_r;
          var_nxt = var_new;
          rto_nxt = RtoW'(sample_r) + RtoW'({var_new, 2'b00});
        end
        state_nxt = ST_OUT;
      end
      // load the result once the output register is free
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, rto_r, var_r, rtt_r, phase_r, thresh_r, window_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mss_r       <= MssReset;
      ceiling_r   <= CeilingReset;
      window_r    <= '0;
      thresh_r    <= ThresholdReset;
      phase_r     <= PH_OPEN;
      rtt_r       <= '0;
      var_r       <= '0;
      rto_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
      thresh_r    <= thresh_nxt;
      phase_r     <= phase_nxt;
      rtt_r       <= rtt_nxt;
      var_r       <= var_nxt;
      rto_r       <= rto_nxt;
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEGMENT_SIZE:   mss_r     <= cfg_data[MssW-1:0];
          CFG_WINDOW_CEILING: ceiling_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    // capture the item on its transfer
    if (in_xfer) begin
      segs_r   <= in_tdata[9:0];
      sample_r <= in_tdata[41:10];
      ev_r     <= in_tdata[44:42];
      ns_r     <= in_tdata[47:45];
    end
  end

endmodule

>>> sim/tcp_congestion_window_control_core_tb.sv
// testbench for tcp_congestion_window_control_core: directed and random items with a
// self-contained Reno window predictor and an in-order scoreboard of expected reports
// depends on tcwc_pkg and the core rtl
`timescale 1ns / 1ps

module tcp_congestion_window_control_core_tb;
  import tcwc_pkg::*;

  // codes the package does not name
  localparam logic [CmdW-1:0]   CMD_SPARE   = 2'd3;
  localparam logic [CodeW-1:0]  EV_OTHER    = 3'd4;
  localparam logic [CodeW-1:0]  EV_TOP      = 3'd7;
  localparam logic [PhaseW-1:0] PH_DISORDER = 3'd1;
  localparam logic [PhaseW-1:0] PH_INVALID  = 3'd7;

  localparam int unsigned IDLE_PCT     = 30;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam logic [63:0] MASK32 = 64'hffff_ffff;
  localparam logic [63:0] MASK35 = 64'h7_ffff_ffff;

  typedef struct packed {
    logic [WordW-1:0]  window_bytes;
    logic [WordW-1:0]  threshold_bytes;
    logic [PhaseW-1:0] phase;
    logic [WordW-1:0]  smoothed_rtt;
    logic [WordW-1:0]  rtt_spread;
    logic [RtoW-1:0]   retransmit_timeout;
  } window_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // segments_acked, rtt_sample, event_code, new_state (lowest first)
  logic [InDataW-1:0]  in_tdata = '0;
  // cmd
  logic [CmdW-1:0]     in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // window_bytes, threshold_bytes, phase, smoothed_rtt, rtt_spread, retransmit_timeout, pad
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [WordW-1:0]    cfg_data = '0;

  // predictor state, held wide so that no product wraps
  logic [63:0]       mss_q      = 64'(MssReset);
  logic [63:0]       ceiling_q  = 64'(CeilingReset);
  logic [63:0]       cwnd_q     = '0;
  logic [63:0]       ssthresh_q = 64'(ThresholdReset);
  logic [PhaseW-1:0] phase_q    = PH_OPEN;
  logic [63:0]       srtt_q     = '0;
  logic [63:0]       rttvar_q   = '0;
  logic [63:0]       rto_q      = '0;

  window_report_t pending_reports[$];
  window_report_t want_rep;
  int unsigned    mismatches = 0;
  int unsigned    items_sent = 0;
  int unsigned    cycle_count = 0;
  bit             no_idle = 1'b0;

  tcp_congestion_window_control_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // reno halving rule: half the window, but never below two segments
  function automatic logic [63:0] halved_ssthresh();
    logic [63:0] half;
    half = cwnd_q >> 1;
    return (half > 2 * mss_q) ? half : 2 * mss_q;
  endfunction

  // advance the predicted window state by one item and queue the report it yields
  task automatic predict_reno(input logic [CmdW-1:0] cmd, input logic [SegsW-1:0] segs,
                              input logic [WordW-1:0] rtt, input logic [CodeW-1:0] ev,
                              input logic [PhaseW-1:0] ns);
    logic [63:0]    grown;
    logic [63:0]    incr;
    logic [63:0]    divisor;
    window_report_t rep;
    // window growth on acks
    if (cmd == CMD_ACK && segs != 0) begin
      if (phase_q == PH_RECOVERY) begin
        grown = cwnd_q + 64'(segs) * mss_q;
      end else if (cwnd_q < ssthresh_q) begin
        grown = cwnd_q + 64'(segs) * mss_q;
        if (grown > ssthresh_q) grown = ssthresh_q;
      end else begin
        divisor = (cwnd_q == 0) ? 64'd1 : cwnd_q;
        incr = (64'(segs) * mss_q * mss_q) / divisor;
        if (incr == 0) incr = 64'd1;
        grown = cwnd_q + incr;
      end
      if (grown > ceiling_q) grown = ceiling_q;
      cwnd_q = grown & MASK32;
    end
    // congestion signals
    if (cmd == CMD_EVENT) begin
      case (ev)
        EV_LOSS: begin
          ssthresh_q = halved_ssthresh();
          phase_q = PH_RECOVERY;
        end
        EV_TIMEOUT: begin
          ssthresh_q = halved_ssthresh();
          cwnd_q = mss_q;
          phase_q = PH_LOSS;
        end
        EV_ECN: begin
          ssthresh_q = halved_ssthresh();
          cwnd_q = ssthresh_q;
          phase_q = PH_CWR;
        end
        EV_FAST_REC: phase_q = PH_RECOVERY;
        default: ;
      endcase
    end
    // rtt estimate, first sample seeds the variance with half of itself
    if ((cmd == CMD_ACK || cmd == CMD_EVENT) && rtt != 0) begin
      srtt_q = 64'(rtt);
      if (rttvar_q == 0) rttvar_q = srtt_q >> 1;
      else rttvar_q = ((3 * rttvar_q + srtt_q) >> 2) & MASK32;
      rto_q = (srtt_q + 4 * rttvar_q) & MASK35;
    end
    // phase writes, out-of-range phases are dropped
    if (cmd == CMD_STATE && ns <= PH_LOSS) begin
      phase_q = ns;
      if (ns == PH_RECOVERY || ns == PH_LOSS) ssthresh_q = halved_ssthresh();
    end
    rep.window_bytes       = cwnd_q[WordW-1:0];
    rep.threshold_bytes    = ssthresh_q[WordW-1:0];
    rep.phase              = phase_q;
    rep.smoothed_rtt       = srtt_q[WordW-1:0];
    rep.rtt_spread         = rttvar_q[WordW-1:0];
    rep.retransmit_timeout = rto_q[RtoW-1:0];
    pending_reports.push_back(rep);
  endtask

  // one input transfer, with a random gap in front of it
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [SegsW-1:0] segs,
                           input logic [WordW-1:0] rtt, input logic [CodeW-1:0] ev,
                           input logic [PhaseW-1:0] ns);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {ns, ev, rtt, segs};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_reno(cmd, segs, rtt, ev, ns);
  endtask

  // stop sending and wait for every outstanding report
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // write both registers back to back while the core is idle
  task automatic write_limits(input logic [MssW-1:0] mss, input logic [WordW-1:0] ceiling);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SEGMENT_SIZE;
    cfg_data  <= {16'd0, mss};
    do @(posedge clk); while (!cfg_ready);
    mss_q = 64'(mss);
    cfg_index <= CFG_WINDOW_CEILING;
    cfg_data  <= ceiling;
    do @(posedge clk); while (!cfg_ready);
    ceiling_q = 64'(ceiling);
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [RtoW-1:0] want,
                                      input logic [RtoW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each result transfer with the oldest expected report
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with no report expected");
        mismatches++;
      end else begin
        want_rep = pending_reports.pop_front();
        check_field("window_bytes", want_rep.window_bytes, out_tdata[31:0]);
        check_field("threshold_bytes", want_rep.threshold_bytes, out_tdata[63:32]);
        check_field("phase", want_rep.phase, out_tdata[66:64]);
        check_field("smoothed_rtt", want_rep.smoothed_rtt, out_tdata[98:67]);
        check_field("rtt_spread", want_rep.rtt_spread, out_tdata[130:99]);
        check_field("retransmit_timeout", want_rep.retransmit_timeout, out_tdata[165:131]);
      end
    end
  end

  function automatic logic [SegsW-1:0] pick_segments();
    case ($urandom_range(3))
      0:       return '0;
      1:       return SegsW'($urandom_range(4, 1));
      2:       return SegsW'($urandom_range(1023));
      default: return SegsW'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_rtt();
    case ($urandom_range(3))
      0:       return '0;
      1:       return $urandom;
      default: return $urandom_range(200000, 1);
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_ceiling();
    case ($urandom_range(2))
      0:       return $urandom_range(200000, 1);
      1:       return $urandom | 32'd1;
      default: return $urandom_range(4000000, 65536);
    endcase
  endfunction

  // slow start from reset values, first variance, ceiling clamp, widest rtt
  task automatic test_reset_growth();
    send_item(CMD_ACK, 10'd1, 32'd0, EV_LOSS, PH_OPEN);
    send_item(CMD_ACK, 10'd0, 32'd1000, EV_TOP, PH_INVALID);
    send_item(CMD_ACK, 10'd1023, 32'hffff_ffff, EV_LOSS, PH_OPEN);
    send_item(CMD_ACK, 10'd2, 32'd1, EV_LOSS, PH_OPEN);
  endtask

  // every event code, recovery growth and one avoidance step
  task automatic test_congestion_events();
    send_item(CMD_EVENT, 10'd0, 32'd0, EV_LOSS, PH_OPEN);
    send_item(CMD_ACK, 10'd3, 32'd0, EV_LOSS, PH_OPEN);
    send_item(CMD_EVENT, 10'h3ff, 32'd200, EV_ECN, PH_INVALID);
    send_item(CMD_ACK, 10'd1, 32'd0, EV_LOSS, PH_OPEN);
    send_item(CMD_EVENT, 10'd0, 32'd5000, EV_TIMEOUT, PH_OPEN);
    send_item(CMD_EVENT, 10'd0, 32'd0, EV_FAST_REC, PH_OPEN);
    send_item(CMD_EVENT, 10'd0, 32'd77, EV_OTHER, PH_OPEN);
    send_item(CMD_EVENT, 10'd0, 32'd0, EV_TOP, PH_OPEN);
  endtask

  // each phase write, an out-of-range phase and the unused command
  task automatic test_phase_writes();
    send_item(CMD_STATE, 10'h3ff, 32'hffff_ffff, EV_TOP, PH_OPEN);
    send_item(CMD_STATE, 10'd0, 32'd0, EV_LOSS, PH_DISORDER);
    send_item(CMD_STATE, 10'd0, 32'd0, EV_LOSS, PH_CWR);
    send_item(CMD_STATE, 10'd0, 32'd0, EV_LOSS, PH_RECOVERY);
    send_item(CMD_STATE, 10'd0, 32'd0, EV_LOSS, PH_LOSS);
    send_item(CMD_STATE, 10'd0, 32'd9, EV_LOSS, PH_INVALID);
    send_item(CMD_SPARE, 10'd5, 32'd123, EV_LOSS, PH_OPEN);
  endtask

  // widest products, then a ceiling below the window and the minimum increment
  task automatic test_window_extremes();
    write_limits(16'hffff, 32'hffff_ffff);
    send_item(CMD_EVENT, 10'd0, 32'd0, EV_TIMEOUT, PH_OPEN);
    send_item(CMD_ACK, 10'd1023, 32'd0, EV_LOSS, PH_OPEN);
    send_item(CMD_ACK, 10'd1023, 32'd0, EV_LOSS, PH_OPEN);
    send_item(CMD_ACK, 10'd1, 32'd0, EV_LOSS, PH_OPEN);
    write_limits(16'd1, 32'd1);
    send_item(CMD_ACK, 10'd5, 32'd0, EV_LOSS, PH_OPEN);
    send_item(CMD_EVENT, 10'd0, 32'd0, EV_ECN, PH_OPEN);
    send_item(CMD_ACK, 10'd1, 32'd0, EV_LOSS, PH_OPEN);
  endtask

  // mostly reno episodes with random content, some loose items in between
  task automatic run_traffic_phase(input logic [MssW-1:0] mss, input logic [WordW-1:0] ceiling,
                                   input bit steady);
    int unsigned first_item;
    int unsigned run_len;
    write_limits(mss, ceiling);
    no_idle = steady;
    first_item = items_sent;
    while (items_sent - first_item < PHASE_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        // growth, a congestion signal, recovery acks, then back to a phase
        run_len = $urandom_range(12, 1);
        repeat (run_len) begin
          send_item(CMD_ACK, pick_segments(), pick_rtt(), CodeW'($urandom_range(7)),
                    PhaseW'($urandom_range(7)));
        end
        send_item(CMD_EVENT, pick_segments(), pick_rtt(), CodeW'($urandom_range(4)),
                  PhaseW'($urandom_range(7)));
        run_len = $urandom_range(6);
        repeat (run_len) begin
          send_item(CMD_ACK, pick_segments(), pick_rtt(), CodeW'($urandom_range(7)),
                    PhaseW'($urandom_range(7)));
        end
        send_item(CMD_STATE, pick_segments(), pick_rtt(), CodeW'($urandom_range(7)),
                  $urandom_range(1) ? PH_OPEN : PhaseW'($urandom_range(4)));
      end else begin
        send_item(CmdW'($urandom_range(2)), pick_segments(), pick_rtt(),
                  CodeW'($urandom_range(4)), PhaseW'($urandom_range(4)));
      end
    end
    no_idle = 1'b0;
  endtask

  // several register settings, extremes included, one phase without any idling
  task automatic test_random_traffic();
    run_traffic_phase(MssReset, CeilingReset, 1'b0);
    run_traffic_phase(16'hffff, 32'hffff_ffff, 1'b1);
    run_traffic_phase(16'd1, 32'd1, 1'b0);
    run_traffic_phase(MssW'($urandom_range(65535, 1)), pick_ceiling(), 1'b0);
    run_traffic_phase(MssW'($urandom_range(2000, 500)), pick_ceiling(), 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_growth();
    test_congestion_events();
    test_phase_writes();
    test_window_extremes();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> tcp_congestion_window_control_core.f
hw/rtl/tcwc_pkg.sv
hw/rtl/tcp_congestion_window_control_core.sv
sim/tcp_congestion_window_control_core_tb.sv
